// File: rtl/core/ddalr_pkg.sv
// shared constants, types and helpers for the dda line rasterizer
// used by ddalr_div and dda_line_rasterizer; depends on nothing

package ddalr_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int COORD_SPAN    = 64;

    localparam int FIELD_W   = 6;
    localparam int PAINT_W   = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // dividend is |dy| shifted up by the fraction bits
    localparam int NUM_W   = FIELD_W + FRACTION_BITS;
    localparam int QCNT_W  = $clog2(NUM_W + 1);
    // slope magnitude never exceeds one whole pixel
    localparam int SLOPE_W = FRACTION_BITS + 2;
    localparam int ACC_W   = FIELD_W + FRACTION_BITS + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     RASTER_RESET      = 7'd64;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [FIELD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [FIELD_W-1:0] clamp_coord(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] c;
        c = v;
        if (int'(v) > COORD_SPAN - 1) begin
            c = FIELD_W'(COORD_SPAN - 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/ddalr_div.sv
// restoring shift-subtract divider, one quotient bit per cycle
// depends on ddalr_pkg for widths and the request/response structs

module ddalr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddalr_pkg::t_div_req i_req,
    output ddalr_pkg::t_div_rsp o_rsp
);

    logic [ddalr_pkg::NUM_W-1:0]   r_num;
    logic [ddalr_pkg::NUM_W-1:0]   r_quot;
    logic [ddalr_pkg::FIELD_W-1:0] r_rem;
    logic [ddalr_pkg::FIELD_W-1:0] r_den;
    logic [ddalr_pkg::QCNT_W-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [ddalr_pkg::FIELD_W:0]   n_rem_sh;
    logic                          n_fits;
    logic [ddalr_pkg::FIELD_W-1:0] n_rem;

    always_comb begin
        n_rem_sh = {r_rem, r_num[ddalr_pkg::NUM_W-1]};
        n_fits   = (n_rem_sh >= {1'b0, r_den});
        // remainder stays below the divisor, so the top bit drops out
        n_rem    = n_fits ? ddalr_pkg::FIELD_W'(n_rem_sh - {1'b0, r_den})
                          : n_rem_sh[ddalr_pkg::FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ddalr_pkg::QCNT_W'(ddalr_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ddalr_pkg::QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[ddalr_pkg::NUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[ddalr_pkg::NUM_W-2:0], n_fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// File: rtl/core/dda_line_rasterizer.sv
// dda line rasterizer: sequencer, minor-axis accumulator and pixel output register
// depends on ddalr_pkg and ddalr_div
//
// usage:
//   a line command enters on the i_in_* channel (valid/ready): two endpoints and a
//   color word. the block answers with one pixel item per step of the major axis on
//   the o_out_* channel, both endpoints included; o_out_last marks the final pixel
//   and o_out_inside_res tells whether the pixel falls inside the raster set by the
//   two config registers (index 0 width, index 1 height, plain write port).
//   o_in_ready is high only while no line is in work. after acceptance a setup
//   state orders the endpoints, then the divider forms the slope at one
//   quotient bit per cycle, then pixels leave at one per cycle while the
//   receiver is ready. a single point skips the divider and gives one pixel.
//   a stalled receiver holds the output register and freezes the pixel stepper;
//   nothing is lost or repeated. the last pixel may still wait in the output
//   register while the next command is accepted.
//   reset is synchronous, active low: the sequencer returns to idle, the output
//   register empties and both raster registers return to 64.

module dda_line_rasterizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ddalr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ddalr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ddalr_pkg::FIELD_W-1:0]   i_in_start_x,
    input  logic [ddalr_pkg::FIELD_W-1:0]   i_in_start_y,
    input  logic [ddalr_pkg::FIELD_W-1:0]   i_in_end_x,
    input  logic [ddalr_pkg::FIELD_W-1:0]   i_in_end_y,
    input  logic [ddalr_pkg::PAINT_W-1:0]   i_in_paint,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ddalr_pkg::FIELD_W-1:0]   o_out_pixel_x,
    output logic [ddalr_pkg::FIELD_W-1:0]   o_out_pixel_y,
    output logic [ddalr_pkg::PAINT_W-1:0]   o_out_pixel_paint,
    output logic                            o_out_inside_res,
    output logic                            o_out_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    localparam int FW = ddalr_pkg::FIELD_W;
    localparam int FB = ddalr_pkg::FRACTION_BITS;

    logic [1:0]                           r_state;
    logic [ddalr_pkg::CFG_W-1:0]          r_width;
    logic [ddalr_pkg::CFG_W-1:0]          r_height;

    // command latched at acceptance
    logic [FW-1:0]                        r_ax, r_ay, r_bx, r_by;
    logic [ddalr_pkg::PAINT_W-1:0]        r_paint;

    // line set up along the major axis
    logic                                 r_swapped;
    logic                                 r_neg;
    logic [FW-1:0]                        r_major;
    logic [FW-1:0]                        r_end;
    logic signed [ddalr_pkg::SLOPE_W-1:0] r_slope;
    logic signed [ddalr_pkg::ACC_W-1:0]   r_acc;

    logic                                 r_out_valid;
    logic [FW-1:0]                        r_out_x, r_out_y;
    logic [ddalr_pkg::PAINT_W-1:0]        r_out_paint;
    logic                                 r_out_inside;
    logic                                 r_out_last;

    logic                                 n_swap;
    logic [FW-1:0]                        n_p0, n_q0, n_p1, n_q1;
    logic [FW-1:0]                        n_maj0, n_min0, n_maj1, n_min1;
    logic [FW:0]                          n_dx, n_dy, n_ddy;
    logic [FW-1:0]                        n_adx, n_ady, n_addy;
    logic [FW-1:0]                        n_den;
    logic [ddalr_pkg::NUM_W-1:0]          n_num;

    logic                                 in_acc;
    logic                                 emit;
    logic                                 emit_last;
    logic [FW-1:0]                        minor;
    logic [FW-1:0]                        px, py;
    logic signed [ddalr_pkg::SLOPE_W-1:0] quot_slope;

    ddalr_pkg::t_div_req                  div_req;
    ddalr_pkg::t_div_rsp                  div_rsp;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // endpoint ordering from the latched command
    always_comb begin
        n_dx   = {1'b0, r_bx} - {1'b0, r_ax};
        n_dy   = {1'b0, r_by} - {1'b0, r_ay};
        n_adx  = n_dx[FW] ? FW'(-n_dx) : n_dx[FW-1:0];
        n_ady  = n_dy[FW] ? FW'(-n_dy) : n_dy[FW-1:0];
        n_swap = (n_ady > n_adx);
        n_p0   = n_swap ? r_ay : r_ax;
        n_q0   = n_swap ? r_ax : r_ay;
        n_p1   = n_swap ? r_by : r_bx;
        n_q1   = n_swap ? r_bx : r_by;
        if (n_p0 > n_p1) begin
            n_maj0 = n_p1;
            n_min0 = n_q1;
            n_maj1 = n_p0;
            n_min1 = n_q0;
        end else begin
            n_maj0 = n_p0;
            n_min0 = n_q0;
            n_maj1 = n_p1;
            n_min1 = n_q1;
        end
        n_ddy  = {1'b0, n_min1} - {1'b0, n_min0};
        n_addy = n_ddy[FW] ? FW'(-n_ddy) : n_ddy[FW-1:0];
        n_den  = n_maj1 - n_maj0;
        n_num  = {n_addy, {FB{1'b0}}};
    end

    assign div_req.start = (r_state == ST_SETUP) && (n_den != '0);
    assign div_req.num   = n_num;
    assign div_req.den   = n_den;

    ddalr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // quotient magnitude is at most one whole pixel, so the low bits carry it all
    always_comb begin
        quot_slope = $signed({1'b0, div_rsp.quot[FB:0]});
        if (r_neg) begin
            quot_slope = -quot_slope;
        end
    end

    assign emit      = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign emit_last = (r_major == r_end);
    // floor of the accumulator is an arithmetic shift; only the low bits leave
    assign minor     = r_acc[FB +: FW];
    assign px        = r_swapped ? minor : r_major;
    assign py        = r_swapped ? r_major : minor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ddalr_pkg::RASTER_RESET;
            r_height <= ddalr_pkg::RASTER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ddalr_pkg::CFG_RASTER_WIDTH:  r_width  <= i_cfg_data;
                ddalr_pkg::CFG_RASTER_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_state <= (n_den != '0) ? ST_DIV : ST_RUN;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (emit && emit_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ax    <= ddalr_pkg::clamp_coord(i_in_start_x);
            r_ay    <= ddalr_pkg::clamp_coord(i_in_start_y);
            r_bx    <= ddalr_pkg::clamp_coord(i_in_end_x);
            r_by    <= ddalr_pkg::clamp_coord(i_in_end_y);
            r_paint <= i_in_paint;
        end
        if (r_state == ST_SETUP) begin
            r_swapped <= n_swap;
            r_neg     <= n_ddy[FW];
            r_major   <= n_maj0;
            r_end     <= n_maj1;
            r_acc     <= $signed({2'b00, n_min0, {FB{1'b0}}});
            // single point: no division, slope stays zero
            r_slope   <= '0;
        end
        if (r_state == ST_DIV && div_rsp.done) begin
            r_slope <= quot_slope;
        end
        if (emit) begin
            r_major      <= r_major + 1'b1;
            r_acc        <= r_acc + ddalr_pkg::ACC_W'(r_slope);
            r_out_x      <= px;
            r_out_y      <= py;
            r_out_paint  <= r_paint;
            r_out_inside <= ({1'b0, px} < r_width) && ({1'b0, py} < r_height);
            r_out_last   <= emit_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_pixel_x     = r_out_x;
    assign o_out_pixel_y     = r_out_y;
    assign o_out_pixel_paint = r_out_paint;
    assign o_out_inside_res  = r_out_inside;
    assign o_out_last        = r_out_last;

    // the stepper never runs past the far endpoint
    a_major_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_major <= r_end))
        else $error("major coordinate ran past the line end");

    // the final pixel sends the sequencer home
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == ST_IDLE && r_out_last && r_out_valid))
        else $error("line did not finish after its last pixel");

    // slope never exceeds one pixel per step
    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |->
        (r_slope <= $signed(ddalr_pkg::SLOPE_W'(1 << FB)) &&
         r_slope >= -$signed(ddalr_pkg::SLOPE_W'(1 << FB))))
        else $error("slope out of range");

    // the divider only reports while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider result outside the divide phase");

    // no item is taken while a line is in work
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !(emit && emit_last)) |=> !o_in_ready)
        else $error("new item accepted while a line is in work");

endmodule

// File: tb/tb_dda_line_rasterizer.sv
// self-checking testbench for dda_line_rasterizer: directed and random line commands and raster sizes,
// every pixel item compared with a local dda predictor
// depends on ddalr_pkg and the rasterizer rtl

module tb_dda_line_rasterizer;

    localparam int MAX_GAP      = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 6;
    localparam int LINES_PER_PHASE = 68;

    typedef struct {
        logic [ddalr_pkg::FIELD_W-1:0] x;
        logic [ddalr_pkg::FIELD_W-1:0] y;
        logic [ddalr_pkg::PAINT_W-1:0] paint;
        logic                          in_raster;
        logic                          last;
    } t_line_pixel;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ddalr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ddalr_pkg::CFG_W-1:0]     i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [ddalr_pkg::FIELD_W-1:0]   i_in_start_x;
    logic [ddalr_pkg::FIELD_W-1:0]   i_in_start_y;
    logic [ddalr_pkg::FIELD_W-1:0]   i_in_end_x;
    logic [ddalr_pkg::FIELD_W-1:0]   i_in_end_y;
    logic [ddalr_pkg::PAINT_W-1:0]   i_in_paint;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [ddalr_pkg::FIELD_W-1:0]   o_out_pixel_x;
    logic [ddalr_pkg::FIELD_W-1:0]   o_out_pixel_y;
    logic [ddalr_pkg::PAINT_W-1:0]   o_out_pixel_paint;
    logic                            o_out_inside_res;
    logic                            o_out_last;

    t_line_pixel                 expected_pixels[$];
    logic [ddalr_pkg::CFG_W-1:0] raster_cols;
    logic [ddalr_pkg::CFG_W-1:0] raster_rows;
    bit                          gaps_on;
    int                          mismatches;

    dda_line_rasterizer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_start_x      (i_in_start_x),
        .i_in_start_y      (i_in_start_y),
        .i_in_end_x        (i_in_end_x),
        .i_in_end_y        (i_in_end_y),
        .i_in_paint        (i_in_paint),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_pixel_x     (o_out_pixel_x),
        .o_out_pixel_y     (o_out_pixel_y),
        .o_out_pixel_paint (o_out_pixel_paint),
        .o_out_inside_res  (o_out_inside_res),
        .o_out_last        (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_pixel(input int x, input int y,
                                       input logic [ddalr_pkg::PAINT_W-1:0] pnt,
                                       input bit is_last);
        t_line_pixel px;
        px.x         = ddalr_pkg::FIELD_W'(x);
        px.y         = ddalr_pkg::FIELD_W'(y);
        px.paint     = pnt;
        px.in_raster = (x < int'(raster_cols)) && (y < int'(raster_rows));
        px.last      = is_last;
        expected_pixels.push_back(px);
    endfunction

    // dda walk along the major axis, minor coordinate floored from the fixed-point accumulator
    function automatic void predict_line(input logic [ddalr_pkg::FIELD_W-1:0] sx,
                                         input logic [ddalr_pkg::FIELD_W-1:0] sy,
                                         input logic [ddalr_pkg::FIELD_W-1:0] ex,
                                         input logic [ddalr_pkg::FIELD_W-1:0] ey,
                                         input logic [ddalr_pkg::PAINT_W-1:0] pnt);
        int ax, ay, bx, by, tmp, adx, ady, step_slope, acc, pos, minor;
        bit steep;
        ax = sx;
        ay = sy;
        bx = ex;
        by = ey;
        if (ax == bx && ay == by) begin
            push_pixel(ax, ay, pnt, 1'b1);
        end else begin
            adx = (bx > ax) ? bx - ax : ax - bx;
            ady = (by > ay) ? by - ay : ay - by;
            // ties keep x as the major axis
            steep = ady > adx;
            if (steep) begin
                tmp = ax; ax = ay; ay = tmp;
                tmp = bx; bx = by; by = tmp;
            end
            if (ax > bx) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            // int division truncates toward zero
            step_slope = ((by - ay) * (1 << ddalr_pkg::FRACTION_BITS)) / (bx - ax);
            acc = ay * (1 << ddalr_pkg::FRACTION_BITS);
            for (pos = ax; pos <= bx; pos++) begin
                minor = acc >>> ddalr_pkg::FRACTION_BITS;
                if (steep) begin
                    push_pixel(minor, pos, pnt, pos == bx);
                end else begin
                    push_pixel(pos, minor, pnt, pos == bx);
                end
                acc += step_slope;
            end
        end
    endfunction

    function automatic logic [ddalr_pkg::FIELD_W-1:0] near_coord(input int c);
        int v;
        v = c + int'($urandom_range(0, 8)) - 4;
        if (v < 0) begin
            v = 0;
        end else if (v > ddalr_pkg::COORD_SPAN - 1) begin
            v = ddalr_pkg::COORD_SPAN - 1;
        end
        return ddalr_pkg::FIELD_W'(v);
    endfunction

    // valid stays up across back-to-back items; it drops when a gap is drawn or the lines are drained
    task automatic send_line(input logic [ddalr_pkg::FIELD_W-1:0] sx,
                             input logic [ddalr_pkg::FIELD_W-1:0] sy,
                             input logic [ddalr_pkg::FIELD_W-1:0] ex,
                             input logic [ddalr_pkg::FIELD_W-1:0] ey,
                             input logic [ddalr_pkg::PAINT_W-1:0] pnt);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_start_x <= sx;
        i_in_start_y <= sy;
        i_in_end_x   <= ex;
        i_in_end_y   <= ey;
        i_in_paint   <= pnt;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_line(sx, sy, ex, ey, pnt);
    endtask

    task automatic wait_lines_done();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_raster(input logic [ddalr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ddalr_pkg::CFG_W-1:0] val);
        wait_lines_done();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ddalr_pkg::CFG_RASTER_WIDTH) begin
            raster_cols = val;
        end else begin
            raster_rows = val;
        end
    endtask

    task automatic send_random_line();
        logic [ddalr_pkg::FIELD_W-1:0] sx, sy, ex, ey, d;
        int kind;
        sx   = ddalr_pkg::FIELD_W'($urandom_range(0, ddalr_pkg::COORD_SPAN - 1));
        sy   = ddalr_pkg::FIELD_W'($urandom_range(0, ddalr_pkg::COORD_SPAN - 1));
        ex   = ddalr_pkg::FIELD_W'($urandom_range(0, ddalr_pkg::COORD_SPAN - 1));
        ey   = ddalr_pkg::FIELD_W'($urandom_range(0, ddalr_pkg::COORD_SPAN - 1));
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            ex = sx;
            ey = sy;
        end else if (kind <= 3) begin
            ex = near_coord(sx);
            ey = near_coord(sy);
        end else if (kind == 4) begin
            // horizontal, vertical or diagonal
            d = ddalr_pkg::FIELD_W'($urandom_range(0, 20));
            case ($urandom_range(0, 2))
                0: ey = sy;
                1: ex = sx;
                default: begin
                    ex = (int'(sx) + int'(d) > ddalr_pkg::COORD_SPAN - 1) ? sx - d : sx + d;
                    ey = (int'(sy) + int'(d) > ddalr_pkg::COORD_SPAN - 1) ? sy - d : sy + d;
                end
            endcase
        end
        send_line(sx, sy, ex, ey, $urandom);
    endtask

    task automatic test_directed_lines();
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_line(6'd0, 6'd0, 6'd63, 6'd0, 32'hA5A5_5A5A);
        send_line(6'd63, 6'd63, 6'd63, 6'd0, 32'h5A5A_A5A5);
        send_line(6'd0, 6'd0, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_line(6'd63, 6'd0, 6'd0, 6'd63, 32'h0000_0000);
        send_line(6'd5, 6'd0, 6'd7, 6'd63, $urandom);
        send_line(6'd63, 6'd10, 6'd0, 6'd12, $urandom);
        send_line(6'd10, 6'd40, 6'd50, 6'd3, $urandom);
        send_line(6'd20, 6'd60, 6'd22, 6'd1, $urandom);
        send_line(6'd0, 6'd63, 6'd1, 6'd62, $urandom);
        send_line(6'd30, 6'd30, 6'd31, 6'd30, $urandom);
        send_line(6'd62, 6'd1, 6'd1, 6'd2, $urandom);
        send_line(6'd7, 6'd0, 6'd0, 6'd3, $urandom);
    endtask

    task automatic test_raster_bounds();
        // zero-sized raster marks every pixel outside
        write_raster(ddalr_pkg::CFG_RASTER_WIDTH, 7'd0);
        send_line(6'd0, 6'd0, 6'd5, 6'd2, $urandom);
        write_raster(ddalr_pkg::CFG_RASTER_WIDTH, 7'd127);
        write_raster(ddalr_pkg::CFG_RASTER_HEIGHT, 7'd0);
        send_line(6'd63, 6'd0, 6'd60, 6'd5, $urandom);
        write_raster(ddalr_pkg::CFG_RASTER_HEIGHT, 7'd127);
        send_line(6'd0, 6'd63, 6'd63, 6'd0, $urandom);
        write_raster(ddalr_pkg::CFG_RASTER_WIDTH, 7'd1);
        write_raster(ddalr_pkg::CFG_RASTER_HEIGHT, 7'd1);
        send_line(6'd0, 6'd0, 6'd3, 6'd1, $urandom);
        send_line(6'd1, 6'd0, 6'd0, 6'd3, $urandom);
        write_raster(ddalr_pkg::CFG_RASTER_WIDTH, 7'd33);
        write_raster(ddalr_pkg::CFG_RASTER_HEIGHT, 7'd64);
        send_line(6'd28, 6'd50, 6'd40, 6'd63, $urandom);
        send_line(6'd32, 6'd10, 6'd33, 6'd20, $urandom);
    endtask

    task automatic test_random_lines();
        int phase, n;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            gaps_on = (phase != 1);
            if ($urandom_range(0, 3) == 0) begin
                write_raster(ddalr_pkg::CFG_RASTER_WIDTH,
                             ddalr_pkg::CFG_W'($urandom_range(0, 127)));
            end else begin
                write_raster(ddalr_pkg::CFG_RASTER_WIDTH,
                             ddalr_pkg::CFG_W'($urandom_range(1, 64)));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_raster(ddalr_pkg::CFG_RASTER_HEIGHT,
                             ddalr_pkg::CFG_W'($urandom_range(0, 127)));
            end else begin
                write_raster(ddalr_pkg::CFG_RASTER_HEIGHT,
                             ddalr_pkg::CFG_W'($urandom_range(1, 64)));
            end
            for (n = 0; n < LINES_PER_PHASE; n++) begin
                send_random_line();
                // now and then let the whole pipeline empty
                if ($urandom_range(0, 31) == 0) begin
                    wait_lines_done();
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin : pixel_checker
        t_line_pixel want;
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel item x=%0d y=%0d", o_out_pixel_x, o_out_pixel_y);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_pixel_x !== want.x) begin
                    $error("pixel_x expected %0d got %0d", want.x, o_out_pixel_x);
                    mismatches++;
                end
                if (o_out_pixel_y !== want.y) begin
                    $error("pixel_y expected %0d got %0d", want.y, o_out_pixel_y);
                    mismatches++;
                end
                if (o_out_pixel_paint !== want.paint) begin
                    $error("pixel_paint expected %h got %h", want.paint, o_out_pixel_paint);
                    mismatches++;
                end
                if (o_out_inside_res !== want.in_raster) begin
                    $error("inside_res expected %0b got %0b", want.in_raster, o_out_inside_res);
                    mismatches++;
                end
                if (o_out_last !== want.last) begin
                    $error("last expected %0b got %0b", want.last, o_out_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= ddalr_pkg::CFG_RASTER_WIDTH;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_in_start_x <= '0;
        i_in_start_y <= '0;
        i_in_end_x   <= '0;
        i_in_end_y   <= '0;
        i_in_paint   <= '0;
        raster_cols  = ddalr_pkg::RASTER_RESET;
        raster_rows  = ddalr_pkg::RASTER_RESET;
        gaps_on      = 1'b1;
        mismatches   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_lines();
        test_raster_bounds();
        test_random_lines();
        wait_lines_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
